>>> rtl/core/fpr_pkg.sv
// Shared types and constants for the framed packet receiver.
package fpr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 24;

  // Reset values of the marker registers.
  localparam logic [ByteW-1:0] StartMarkerReset = 8'h02;
  localparam logic [ByteW-1:0] EndMarkerReset   = 8'h03;

  // Register indexes, taken from address bit 2.
  localparam logic RegStartMarker = 1'b0;
  localparam logic RegEndMarker   = 1'b1;

  // Result kinds.
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // Frame status codes.
  localparam logic [StatusW-1:0] StatusGood   = 2'd0;
  localparam logic [StatusW-1:0] StatusBadSum = 2'd1;
  localparam logic [StatusW-1:0] StatusNoEnd  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CHK  = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } markers_t;

  typedef struct packed {
    logic               result_kind;
    logic [ByteW-1:0]   payload_byte;
    logic [ByteW-1:0]   byte_index;
    logic [StatusW-1:0] frame_status;
  } result_t;

endpackage

>>> rtl/core/framed_packet_receiver_core.sv
// Top level of the framed packet receiver: STX, length, payload, XOR checksum, ETX.
//
// The in_ channel carries one received byte per transfer on in_tdata. The block
// hunts for the start marker, reads a length byte, passes each payload byte to
// the out_ channel with its index, checks the XOR checksum byte and then the
// end marker. out_tuser marks a payload byte (0) or a frame status (1); a
// status follows the end-marker byte, or the checksum byte when it mismatches.
// Hunting, length and matching checksum bytes yield no transfer on out_.
// A byte is held in the input register, then parsed into the result register.
// One byte is taken every cycle, limited only by the single result register
// draining to out_. When out_tready is low with a result waiting, no byte is
// parsed at all; the input register holds its byte (or loads one if empty)
// and in_tready falls until the result drains. Reset (rst_n low, synchronous)
// empties both registers, returns the parser to hunting and sets the markers
// to 0x02 and 0x03. The user must rewrite the markers through the cfg_ port
// (start at 0x0, end at 0x4) only while idle; the block does not enforce it.
module framed_packet_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [7:0] payload_byte, [15:8] byte_index,
                                    // [17:16] frame_status, [23:18] zero
  output logic        out_tuser,    // [0] result_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fpr_pkg::*;

  markers_t         markers;
  logic             take;
  logic             byte_valid;
  logic [ByteW-1:0] byte_data;
  result_t          result;

  fpr_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .markers     (markers)
  );

  fpr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  fpr_deframer u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .markers    (markers),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .result     (result)
  );

  // Pack the result onto the stream bus.
  assign out_tuser = result.result_kind;
  assign out_tdata = {{(OutDataW-2*ByteW-StatusW){1'b0}}, result.frame_status,
                      result.byte_index, result.payload_byte};

endmodule

>>> rtl/core/fpr_cfg_regs.sv
// Marker configuration registers behind the APB-style port.
module fpr_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [fpr_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [fpr_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [fpr_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                     cfg_pready,
  output fpr_pkg::markers_t        markers
);
  import fpr_pkg::*;

  logic             wr_en;
  logic             reg_sel;
  logic [ByteW-1:0] start_marker_r;
  logic [ByteW-1:0] end_marker_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= StartMarkerReset;
      end_marker_r   <= EndMarkerReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegStartMarker: start_marker_r <= cfg_pwdata[ByteW-1:0];
        RegEndMarker:   end_marker_r   <= cfg_pwdata[ByteW-1:0];
        default:        ;
      endcase
    end
  end

  // Read data is the selected register, zero-extended.
  always_comb begin
    unique case (reg_sel)
      RegStartMarker: cfg_prdata = {{(CfgDataW-ByteW){1'b0}}, start_marker_r};
      RegEndMarker:   cfg_prdata = {{(CfgDataW-ByteW){1'b0}}, end_marker_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign markers.start_marker = start_marker_r;
  assign markers.end_marker   = end_marker_r;

endmodule

>>> rtl/core/fpr_in_stage.sv
// Input register that holds one received byte until the deframer takes it.
module fpr_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [fpr_pkg::ByteW-1:0] in_tdata,
  input  logic                    take,
  output logic                    byte_valid,
  output logic [fpr_pkg::ByteW-1:0] byte_data
);
  import fpr_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [ByteW-1:0] data_r;
  logic             load;

  // The register may refill in the same cycle that its byte is taken.
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

>>> rtl/core/fpr_deframer.sv
// Frame parser state machine with its result register.
module fpr_deframer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fpr_pkg::markers_t       markers,
  input  logic                    byte_valid,
  input  logic [fpr_pkg::ByteW-1:0] byte_data,
  output logic                    take,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output fpr_pkg::result_t        result
);
  import fpr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] remaining_r, remaining_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic [ByteW-1:0] index_r, index_nxt;
  logic             res_valid;
  result_t          res;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r;

  // A byte is consumed whenever the result register is free or draining.
  assign take = byte_valid && (!out_valid_r || out_tready);

  // Next state and the result produced by the current byte.
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    xor_nxt       = xor_r;
    index_nxt     = index_r;
    res_valid     = 1'b0;
    res           = '0;
    unique case (phase_r)
      PH_LEN: begin
        remaining_nxt = byte_data;
        phase_nxt     = (byte_data == '0) ? PH_CHK : PH_DATA;
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.result_kind  = KindPayload;
        res.payload_byte = byte_data;
        res.byte_index   = index_r;
        res.frame_status = StatusGood;
        xor_nxt          = xor_r ^ byte_data;
        index_nxt        = index_r + 8'd1;
        remaining_nxt    = remaining_r - 8'd1;
        if (remaining_r == 8'd1) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        if (byte_data == xor_r) begin
          phase_nxt = PH_END;
        end else begin
          phase_nxt        = PH_HUNT;
          res_valid        = 1'b1;
          res.result_kind  = KindStatus;
          res.frame_status = StatusBadSum;
        end
      end
      PH_END: begin
        phase_nxt        = PH_HUNT;
        res_valid        = 1'b1;
        res.result_kind  = KindStatus;
        res.frame_status = (byte_data == markers.end_marker) ? StatusGood : StatusNoEnd;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (byte_data == markers.start_marker) begin
          remaining_nxt = '0;
          xor_nxt       = '0;
          index_nxt     = '0;
          phase_nxt     = PH_LEN;
        end
      end
    endcase
  end

  // Frame state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remaining_r <= '0;
      xor_r       <= '0;
      index_r     <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
      index_r     <= index_nxt;
    end
  end

  // Result register: loads on a producing byte, empties on a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign result     = out_r;

endmodule
